FILE: sv/ssaw_pkg.sv
// Shared types, constants and the detune offset table for the super saw oscillator.
// No dependencies; every other file of the block imports this package.
package ssaw_pkg;

  // Phase and sample widths.
  localparam int PHASE_W = 32;
  localparam int QUO_W = 32;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DETUNE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX = 4'd1;

  // Unity in the 0.16 side weight format.
  localparam logic [16:0] M_ONE = 17'd65536;

  // The divider retires DIV_STEP quotient bits at a time until all QUO_W bits are formed.
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC = QUO_W / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  // Detune offsets in Q1.15, from the leftmost side saw to the rightmost one.
  localparam int OFF_W = 13;
  localparam logic signed [OFF_W-1:0] OFFSET_Q15 [7] = '{
    -13'sd3605, -13'sd2061, -13'sd640, 13'sd0, 13'sd652, 13'sd2037, 13'sd3521
  };

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAWS,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  // Increment pipeline result: one detuned increment per valid cycle.
  typedef struct packed {
    logic               valid;
    logic [PHASE_W-1:0] inc;
  } incr_t;

  // Divider status towards the controller.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_res_t;

  // Offset for a saw at signed distance d from the middle saw; saws farther
  // out than three places take the outermost offset on their side.
  function automatic logic signed [OFF_W-1:0] offset_q15(input logic signed [7:0] d);
    logic signed [7:0] dc;
    dc = d;
    if (dc < -8'sd3) begin
      dc = -8'sd3;
    end
    if (dc > 8'sd3) begin
      dc = 8'sd3;
    end
    return OFFSET_Q15[3'(dc + 8'sd3)];
  endfunction

endpackage

FILE: sv/ssaw_if.sv
// Handshake interfaces for the input, result and configuration channels.
// Depends on ssaw_pkg for the configuration port widths.
interface ssaw_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        base_increment;
  logic signed [15:0] lfo_value;

  modport source (output valid, output base_increment, output lfo_value, input ready);
  modport sink (input valid, input base_increment, input lfo_value, output ready);
endinterface

interface ssaw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface ssaw_cfg_if;
  import ssaw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/ssaw_cell.sv
// One phase cell of the saw ring: holds one accumulator and takes its
// neighbour's value whenever the ring shifts. Depends on ssaw_pkg.
module ssaw_cell #(
  parameter logic [31:0] RESET_PHASE = 32'h0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  logic [31:0] phase_in,
  output logic [31:0] phase_out
);
  import ssaw_pkg::*;

  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] phase_nxt;

  // Take the neighbour's phase on a shift, otherwise hold.
  always_comb begin
    phase_nxt = shift_en ? phase_in : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= RESET_PHASE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign phase_out = phase_r;

endmodule

FILE: sv/ssaw_incr.sv
// Two-stage pipeline that forms the detuned phase increment of one saw per
// cycle: detune factor, then base times factor, then saturation.
// Depends on ssaw_pkg.
module ssaw_incr #(
  parameter int SAW_COUNT = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         issue,
  input  logic [$clog2(SAW_COUNT)-1:0] idx,
  input  logic [31:0]                  base,
  input  logic [15:0]                  detune,
  output ssaw_pkg::incr_t              res
);
  import ssaw_pkg::*;

  localparam int MID = SAW_COUNT / 2;

  logic                     v1_r;
  logic                     v2_r;
  logic [PHASE_W-1:0]       fac_r;
  logic [PHASE_W-1:0]       fac_nxt;
  logic [2*PHASE_W-1:0]     prod_r;
  logic [2*PHASE_W-1:0]     prod_nxt;
  logic signed [7:0]        rel_pos;
  logic signed [OFF_W-1:0]  off;
  logic signed [OFF_W+16:0] dprod;
  logic signed [33:0]       fac_sum;

  // Stage one: factor = 2^31 + detune * offset, always positive and below 2^32.
  always_comb begin
    rel_pos = 8'(idx) - 8'(MID);
    off = offset_q15(rel_pos);
    dprod = $signed({1'b0, detune}) * off;
    fac_sum = 34'sd2147483648 + 34'(dprod);
    fac_nxt = fac_sum[31:0];
  end

  // Stage two: full product of base and factor.
  always_comb begin
    prod_nxt = 64'(base) * 64'(fac_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    fac_r <= fac_nxt;
    prod_r <= prod_nxt;
  end

  // Scale back by 2^31 and saturate to just under one cycle.
  always_comb begin
    res.valid = v2_r;
    res.inc = prod_r[63] ? '1 : prod_r[62:31];
  end

endmodule

FILE: sv/ssaw_div.sv
// Signed divider for the mix normalisation: restoring division of the
// magnitude, DIV_STEP quotient bits per cycle. Depends on ssaw_pkg.
module ssaw_div #(
  parameter int NUM_W = 72,
  parameter int DEN_W = 21
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output ssaw_pkg::div_res_t      res
);
  import ssaw_pkg::*;

  logic                 busy_r;
  logic                 busy_nxt;
  logic                 done_r;
  logic                 done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     rem_nxt;
  logic [QUO_W-1:0]     q_r;
  logic [QUO_W-1:0]     q_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     den_nxt;
  logic                 neg_r;
  logic                 neg_nxt;
  logic [NUM_W-1:0]     mag;

  // The weighted mean never leaves the q31 range, so the magnitude is below
  // den * 2^32 and the upper part fits the remainder register.
  always_comb begin
    mag = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
  end

  // Control and datapath of the iteration.
  always_comb begin
    logic [DEN_W-1:0] r;
    logic [QUO_W-1:0] q;
    logic [DEN_W:0]   r2;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    r = rem_r;
    q = q_r;
    r2 = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = mag[QUO_W +: DEN_W];
      q_nxt = mag[QUO_W-1:0];
      den_nxt = den;
      neg_nxt = num[NUM_W-1];
    end else if (busy_r) begin
      for (int k = 0; k < DIV_STEP; k++) begin
        r2 = {r, q[QUO_W-1]};
        q = {q[QUO_W-2:0], 1'b0};
        if (r2 >= {1'b0, den_r}) begin
          r2 = r2 - {1'b0, den_r};
          q[0] = 1'b1;
        end
        r = r2[DEN_W-1:0];
      end
      rem_nxt = r;
      q_nxt = q;
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Quotient truncated toward zero; it stays valid until the next start.
  always_comb begin
    res.done = done_r;
    res.quotient = neg_r ? (~q_r + QUO_W'(1)) : q_r;
  end

endmodule

FILE: sv/super_saw_oscillator.sv
// Super saw oscillator: a ring of phase cells, a shared increment pipeline,
// the mixing multiplier and a multi-cycle divider. Depends on ssaw_pkg,
// the channel interfaces, ssaw_cell, ssaw_incr and ssaw_div.
//
// Use: each item on in_ch (base_increment, lfo_value) asks for one sample;
// one item comes back on out_ch carrying sample_out in q31. cfg_ch writes
// detune_amount (index 0) and mix_amount (index 1); it is always ready and
// other indexes are ignored. Write configuration only while the block is idle.
// in_ch.ready returns in the cycle after the result register is loaded, so
// the block takes no new item before it is through with the last one. Each
// item passes through the phase ring, which streams one saw per cycle through
// the increment pipeline, and the divider, which retires four quotient bits a
// cycle. The result waits in an output register: a stalled receiver holds the
// sample there while the next item is already being worked on, and the block
// only waits before loading a new sample into a full register.
// Reset clears both configuration registers and sets saw i to phase
// i * (0xFFFFFFFF / SAW_COUNT).
module super_saw_oscillator #(
  parameter int SAW_COUNT = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  ssaw_in_if.sink    in_ch,
  ssaw_out_if.source out_ch,
  ssaw_cfg_if.sink   cfg_ch
);
  import ssaw_pkg::*;

  localparam int IDX_W = $clog2(SAW_COUNT);
  localparam int CNT_W = $clog2(SAW_COUNT + 1);
  localparam int MID = SAW_COUNT / 2;
  localparam int SUM_W = PHASE_W + $clog2(SAW_COUNT);
  localparam int NUM_W = SUM_W + 19;
  localparam int DEN_W = 18 + $clog2(SAW_COUNT);
  localparam logic [63:0] PHASE_STEP = 64'hFFFF_FFFF / SAW_COUNT;

  state_t state_r;
  state_t state_nxt;

  logic [15:0]              detune_r;
  logic [15:0]              detune_nxt;
  logic [15:0]              mix_r;
  logic [15:0]              mix_nxt;
  logic [PHASE_W-1:0]       base_r;
  logic [PHASE_W-1:0]       base_nxt;
  logic [16:0]              m_r;
  logic [16:0]              m_nxt;
  logic signed [19:0]       m_raw;
  logic [CNT_W-1:0]         iss_cnt_r;
  logic [CNT_W-1:0]         iss_cnt_nxt;
  logic [IDX_W-1:0]         ret_cnt_r;
  logic [IDX_W-1:0]         ret_cnt_nxt;
  logic signed [31:0]       mid_r;
  logic signed [31:0]       mid_nxt;
  logic signed [SUM_W-1:0]  side_r;
  logic signed [SUM_W-1:0]  side_nxt;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [NUM_W-1:0]  num_nxt;
  logic [DEN_W-1:0]         den_r;
  logic [DEN_W-1:0]         den_nxt;
  logic signed [SUM_W+17:0] side_prod;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [31:0]       out_data_r;
  logic signed [31:0]       out_data_nxt;

  logic               in_acc;
  logic               issue;
  logic               last_ret;
  logic               div_start;
  logic               out_load;
  logic signed [31:0] saw_val;
  logic [PHASE_W-1:0] phase_w [SAW_COUNT];
  incr_t              incr;
  div_res_t           div_res;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign last_ret = incr.valid && (ret_cnt_r == IDX_W'(SAW_COUNT - 1));

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    detune_nxt = detune_r;
    mix_nxt = mix_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DETUNE: detune_nxt = cfg_ch.data;
        REG_MIX:    mix_nxt = cfg_ch.data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detune_r <= '0;
      mix_r <= '0;
    end else begin
      detune_r <= detune_nxt;
      mix_r <= mix_nxt;
    end
  end

  // Controller: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SAWS;
      ST_SAWS:  if (last_ret) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_res.done) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Controller: outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    issue = 1'b0;
    div_start = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_SAWS:  issue = (iss_cnt_r != CNT_W'(SAW_COUNT));
      ST_START: div_start = 1'b1;
      ST_DONE:  out_load = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Side weight m = clip(1 - mix - lfo) in 0.16, formed once per item.
  always_comb begin
    m_raw = 20'(M_ONE) - 20'(mix_r) - {{3{in_ch.lfo_value[15]}}, in_ch.lfo_value, 1'b0};
    if (m_raw[19]) begin
      m_nxt = '0;
    end else if (m_raw > 20'(M_ONE)) begin
      m_nxt = M_ONE;
    end else begin
      m_nxt = m_raw[16:0];
    end
    base_nxt = in_ch.base_increment;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_r <= m_nxt;
      base_r <= base_nxt;
    end
  end

  // Increment pipeline, one saw issued per cycle.
  ssaw_incr #(
    .SAW_COUNT(SAW_COUNT)
  ) u_incr (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .idx    (iss_cnt_r[IDX_W-1:0]),
    .base   (base_r),
    .detune (detune_r),
    .res    (incr)
  );

  // Ring of phase cells; the head saw is advanced and re-enters at the tail.
  for (genvar i = 0; i < SAW_COUNT; i++) begin : g_cell
    localparam logic [63:0] RST64 = 64'(i) * PHASE_STEP;
    logic [PHASE_W-1:0] cell_in;
    if (i == SAW_COUNT - 1) begin : g_tail
      assign cell_in = phase_w[0] + incr.inc;
    end else begin : g_body
      assign cell_in = phase_w[i + 1];
    end
    ssaw_cell #(
      .RESET_PHASE(RST64[31:0])
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (incr.valid),
      .phase_in  (cell_in),
      .phase_out (phase_w[i])
    );
  end

  // Saw value phase - 2^31, read before the phase is advanced.
  assign saw_val = {~phase_w[0][31], phase_w[0][30:0]};

  // Issue and retire counters, and the middle and side sums.
  always_comb begin
    iss_cnt_nxt = iss_cnt_r;
    ret_cnt_nxt = ret_cnt_r;
    mid_nxt = mid_r;
    side_nxt = side_r;
    if (in_acc) begin
      iss_cnt_nxt = '0;
      ret_cnt_nxt = '0;
      side_nxt = '0;
    end else begin
      if (issue) begin
        iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
      end
      if (incr.valid) begin
        ret_cnt_nxt = last_ret ? '0 : ret_cnt_r + IDX_W'(1);
        if (ret_cnt_r == IDX_W'(MID)) begin
          mid_nxt = saw_val;
        end else begin
          side_nxt = side_r + SUM_W'(saw_val);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_cnt_r <= '0;
      ret_cnt_r <= '0;
    end else begin
      iss_cnt_r <= iss_cnt_nxt;
      ret_cnt_r <= ret_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
    side_r <= side_nxt;
  end

  // Numerator 65536 * middle + m * sides and denominator 65536 + (N-1) * m.
  always_comb begin
    side_prod = side_r * $signed({1'b0, m_r});
    num_nxt = (NUM_W'(mid_r) <<< 16) + NUM_W'(side_prod);
    den_nxt = DEN_W'(M_ONE) + DEN_W'(m_r) * DEN_W'(SAW_COUNT - 1);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  ssaw_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .res   (div_res)
  );

  // Output register; the weighted mean cannot leave the q31 range.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = div_res.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  // The ring only shifts while the saws of an item are being processed.
  a_shift_in_saws: assert property (@(posedge clk) disable iff (!rst_n)
    incr.valid |-> state_r == ST_SAWS)
    else $error("phase ring shifted outside the saw pass");

  // After the last saw retires, the numerator is formed next.
  a_last_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    last_ret |=> state_r == ST_MUL)
    else $error("saw pass did not hand over to the multiplier");

  // The divider finishes only while the controller waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  // An accepted item starts a fresh pass with cleared counters.
  a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SAWS) && (iss_cnt_r == '0) && (ret_cnt_r == '0))
    else $error("saw pass did not start cleanly");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the seven-voice super saw oscillator.
// Depends on ssaw_pkg, the channel interfaces in ssaw_if.sv and the oscillator itself;
// expected samples come from a predictor of the phase ring and the weighted mix.
module tb;
  import ssaw_pkg::*;

  localparam int SAW_TOTAL = 7;
  localparam int MID_SAW = SAW_TOTAL / 2;
  localparam int STALL_PCT = 21;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int SWEEP_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 148;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  // Detune offsets in Q1.15, leftmost side saw first.
  localparam int DETUNE_OFFSET [SAW_TOTAL] = '{-3605, -2061, -640, 0, 652, 2037, 3521};

  logic clk = 1'b0;
  logic rst_n;

  ssaw_in_if  in_ch ();
  ssaw_out_if out_ch ();
  ssaw_cfg_if cfg_ch ();

  super_saw_oscillator #(
    .SAW_COUNT(SAW_TOTAL)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predictor state: saw phases and the two configuration registers.
  logic [31:0]        saw_phase [SAW_TOTAL];
  logic [15:0]        detune_reg;
  logic [15:0]        mix_reg;
  logic signed [31:0] expected_samples [$];
  logic signed [31:0] oldest_sample;

  int  items_sent;
  int  samples_checked;
  int  cfg_writes;
  int  fail_count;
  int  idle_cycles;
  bit  no_idle;

  // Clock with a period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Detuned increment of one saw, saturated just below one cycle.
  function automatic logic [31:0] detuned_increment(input logic [31:0] base, input int off);
    logic [63:0] factor;
    logic [63:0] prod;
    logic [63:0] inc;
    factor = 64'sd2147483648 + longint'(detune_reg) * longint'(off);
    prod = 64'(base) * factor;
    inc = prod >> 31;
    if (inc > 64'hFFFF_FFFF) begin
      inc = 64'hFFFF_FFFF;
    end
    return inc[31:0];
  endfunction

  // Works out the next sample from the current phases, then advances every saw.
  function automatic logic signed [31:0] predict_sample(input logic [31:0] base,
                                                        input logic signed [15:0] lfo);
    int     weight;
    longint saw_value;
    longint mid_sum;
    longint side_sum;
    longint num;
    longint den;
    longint quo;
    weight = 65536 - int'(mix_reg) - 2 * int'(lfo);
    if (weight < 0) begin
      weight = 0;
    end
    if (weight > 65536) begin
      weight = 65536;
    end
    mid_sum = 0;
    side_sum = 0;
    for (int i = 0; i < SAW_TOTAL; i++) begin
      saw_value = longint'(saw_phase[i]) - 64'sd2147483648;
      if (i == MID_SAW) begin
        mid_sum += saw_value;
      end else begin
        side_sum += saw_value;
      end
      saw_phase[i] = saw_phase[i] + detuned_increment(base, DETUNE_OFFSET[i]);
    end
    num = mid_sum * 65536 + side_sum * longint'(weight);
    den = 65536 + longint'(SAW_TOTAL - 1) * longint'(weight);
    quo = num / den;
    if (quo > 64'sd2147483647) begin
      quo = 64'sd2147483647;
    end
    if (quo < -64'sd2147483648) begin
      quo = -64'sd2147483648;
    end
    return quo[31:0];
  endfunction

  // Counts a failure and reports the first few of them.
  function automatic void note_mismatch(input string what, input logic signed [31:0] exp_val,
                                        input logic signed [31:0] act_val);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("Mismatch (%s): expected %0d (0x%08h), got %0d (0x%08h)",
               what, exp_val, exp_val, act_val, act_val);
    end
  endfunction

  // Sends one item, with a random gap before it unless idling is switched off.
  task automatic send_item(input logic [31:0] base, input logic signed [15:0] lfo);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.base_increment = base;
    in_ch.lfo_value = lfo;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    expected_samples.push_back(predict_sample(base, lfo));
    items_sent++;
  endtask

  // Lowers valid and waits until every outstanding sample has come back.
  task automatic drain;
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (expected_samples.size() == 0);
    @(negedge clk);
  endtask

  // Writes one register; the predictor follows only the known indexes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    if (idx == REG_DETUNE) begin
      detune_reg = value;
    end else if (idx == REG_MIX) begin
      mix_reg = value;
    end
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Brings the block to rest and loads both registers.
  task automatic set_config(input logic [15:0] detune, input logic [15:0] mix);
    drain();
    write_reg(REG_DETUNE, detune);
    write_reg(REG_MIX, mix);
  endtask

  // Reset settings: no detune, full side weight, the side weight clipped at unity and brought near zero.
  task automatic test_reset_settings;
    send_item(32'h0000_0000, 16'sh0000);
    send_item(32'hFFFF_FFFF, 16'sh0000);
    send_item(32'h0125_3C82, -16'sh8000);
    send_item(32'h0125_3C82, 16'sh7FFF);
    send_item(32'h0000_0001, 16'sh0001);
  endtask

  // Full detune: the positive offsets push large increments past one cycle.
  task automatic test_detune_extremes;
    set_config(16'hFFFF, 16'h0000);
    send_item(32'hFFFF_FFFF, 16'sh0000);
    send_item(32'hD000_0000, 16'sh1000);
    send_item(32'h8000_0000, -16'sh0800);
    send_item(32'h0000_0000, 16'sh0000);
  endtask

  // Maximum mix: the side weight falls to zero, to one, and is lifted back to unity.
  task automatic test_mix_extremes;
    set_config(16'h8000, 16'hFFFF);
    send_item(32'h0ABC_DEF0, 16'sh0000);
    send_item(32'h0ABC_DEF0, 16'sh0001);
    send_item(32'h7FFF_FFFF, -16'sh0001);
    send_item(32'h7FFF_FFFF, -16'sh8000);
    send_item(32'h5555_5555, 16'sh7FFF);
  endtask

  // A write to an index that holds no register must leave both registers alone.
  task automatic test_unknown_index;
    set_config(16'h0000, 16'h4000);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(32'h0200_0000, 16'sh0000);
    send_item(32'hF000_0000, 16'sh2000);
    send_item(32'h3333_3333, -16'sh2000);
  endtask

  // Random items over several register settings, one phase without any idling.
  task automatic test_random_sweep;
    logic [15:0]        detune;
    logic [15:0]        mix;
    logic [31:0]        base;
    logic signed [15:0] lfo;
    for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
      case (phase)
        0: begin
          detune = 16'h0000;
          mix = 16'h0000;
        end
        1: begin
          detune = 16'hFFFF;
          mix = 16'hFFFF;
        end
        2: begin
          detune = 16'hFFFF;
          mix = 16'h0000;
        end
        3: begin
          detune = 16'h0000;
          mix = 16'hFFFF;
        end
        default: begin
          detune = 16'($urandom());
          mix = 16'($urandom());
        end
      endcase
      set_config(detune, mix);
      no_idle = (phase == 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case ($urandom_range(3))
          0: base = $urandom();
          1: base = $urandom_range(32'h0400_0000);
          2: base = 32'hFFFF_FFFF - $urandom_range(32'h0001_FFFF);
          default: base = $urandom_range(255);
        endcase
        case ($urandom_range(2))
          0: lfo = 16'($urandom());
          1: lfo = 16'($urandom_range(4095)) - 16'sd2048;
          default: lfo = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
        endcase
        send_item(base, lfo);
      end
      no_idle = 1'b0;
    end
  endtask

  // Result side: random stalls unless idling is switched off.
  always @(negedge clk) begin
    out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= STALL_PCT);
  end

  // Each accepted result is checked against the oldest expected sample.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        note_mismatch("unexpected item", 32'sd0, out_ch.sample_out);
      end else begin
        oldest_sample = expected_samples.pop_front();
        samples_checked++;
        if (out_ch.sample_out !== oldest_sample) begin
          note_mismatch("sample_out", oldest_sample, out_ch.sample_out);
        end
      end
    end
  end

  // Ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    // Known values on every input from the start.
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.base_increment = '0;
    in_ch.lfo_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    no_idle = 1'b0;
    items_sent = 0;
    samples_checked = 0;
    cfg_writes = 0;
    fail_count = 0;
    idle_cycles = 0;

    // Predictor reset: no detune, no mix, saws spread evenly over one cycle.
    detune_reg = '0;
    mix_reg = '0;
    for (int i = 0; i < SAW_TOTAL; i++) begin
      saw_phase[i] = 32'(i * (32'hFFFF_FFFF / SAW_TOTAL));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_settings();
    test_detune_extremes();
    test_mix_extremes();
    test_unknown_index();
    test_random_sweep();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      fail_count += expected_samples.size();
    end

    $display("Sent %0d items and checked %0d samples across %0d register writes,",
             items_sent, samples_checked, cfg_writes);
    $display("covering detune and mix extremes, clipped side weights and overflowing increments.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ssaw_pkg.sv
sv/ssaw_if.sv
sv/ssaw_cell.sv
sv/ssaw_incr.sv
sv/ssaw_div.sv
sv/super_saw_oscillator.sv
verif/tb.sv
